// ----- rtl/bftm_pkg.sv -----
// ----------------------------------------------------------------------------
// bftm_pkg
// Shared types and constants for the bitmap font text measure block.
// ----------------------------------------------------------------------------
package bftm_pkg;

    localparam int GLYPH_SLOTS_DEF = 512;
    localparam int Q_DEPTH         = 2;
    localparam int DIV_STEPS       = 16;

    localparam logic [7:0] CODE_RETURN  = 8'd13;
    localparam logic [8:0] MISSING_STEP = 9'd1;

    typedef enum logic [2:0] {
        CFG_FIRST_CHAR    = 3'd0,
        CFG_LAST_CHAR     = 3'd1,
        CFG_EXTRA_WIDTH   = 3'd2,
        CFG_SCALE_NUMER   = 3'd3,
        CFG_SCALE_DENOM   = 3'd4,
        CFG_RETURN_RESETS = 3'd5
    } cfg_index_t;

    typedef enum logic {
        OP_LOAD    = 1'b0,
        OP_MEASURE = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_LEAD,
        BK_ADD,
        BK_MUL,
        BK_CHK,
        BK_DIV,
        BK_EMIT
    } back_state_t;

    typedef struct packed {
        logic [7:0]  first_char;
        logic [7:0]  last_char;
        logic [15:0] extra_width;
        logic [15:0] scale_numer;
        logic [15:0] scale_denom;
        logic        return_resets;
    } bftm_cfg_t;

    typedef struct packed {
        logic       first;
        logic       last;
        logic       is_return;
        logic [7:0] glyph_width;
    } bftm_cmd_t;

endpackage

// ----- rtl/bftm_front.sv -----
// ----------------------------------------------------------------------------
// bftm_front
// Accepts items, writes the glyph width table on loads and looks up the
// glyph width of measure items, then hands them to the command queue.
// ----------------------------------------------------------------------------
module bftm_front #(
    parameter int GLYPH_SLOTS = bftm_pkg::GLYPH_SLOTS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bftm_pkg::bftm_cfg_t  cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 operation,
    input  logic [7:0]           char_code,
    input  logic [7:0]           glyph_width,
    input  logic                 first_of_text,
    input  logic                 last_of_text,
    output logic                 q_push,
    output bftm_pkg::bftm_cmd_t  q_data,
    input  logic                 q_full
);
    import bftm_pkg::*;

    localparam int IDX_W = (GLYPH_SLOTS > 1) ? $clog2(GLYPH_SLOTS) : 1;

    function automatic logic [IDX_W-1:0] slot_of(input logic [8:0] v);
        logic [17:0] r;
        logic [17:0] m;
        r = {9'd0, v};
        for (int k = 8; k >= 0; k--)
        begin
            m = 18'(GLYPH_SLOTS) << k;
            if (r >= m)
            begin
                r = r - m;
            end
        end
        return r[IDX_W-1:0];
    endfunction

    logic [7:0] width_mem [GLYPH_SLOTS];
    logic [7:0] rd_data_reg;

    logic pend_reg;
    logic pend_next;
    logic first_reg;
    logic last_reg;
    logic ret_reg;

    logic       accept;
    logic       wr_en;
    logic       rd_en;
    logic [8:0] glyph_idx;
    logic       in_range;

    assign in_ready = !pend_reg || !q_full;
    assign accept   = in_valid && in_ready;
    assign wr_en    = accept && (op_t'(operation) == OP_LOAD);
    assign rd_en    = accept && (op_t'(operation) == OP_MEASURE);

    assign in_range  = (char_code >= cfg.first_char) && (char_code <= cfg.last_char);
    assign glyph_idx = in_range ? ({1'b0, char_code} - {1'b0, cfg.first_char})
                                : ({1'b0, cfg.last_char} + MISSING_STEP
                                   - {1'b0, cfg.first_char});

    assign q_push    = pend_reg && !q_full;
    assign pend_next = rd_en || (pend_reg && !q_push);

    assign q_data.first       = first_reg;
    assign q_data.last        = last_reg;
    assign q_data.is_return   = ret_reg;
    assign q_data.glyph_width = rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            width_mem[slot_of({1'b0, char_code})] <= glyph_width;
        end
        if (rd_en)
        begin
            rd_data_reg <= width_mem[slot_of(glyph_idx)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            first_reg <= first_of_text;
            last_reg  <= last_of_text;
            ret_reg   <= cfg.return_resets && (char_code == CODE_RETURN);
        end
    end

endmodule

// ----- rtl/bftm_queue.sv -----
// ----------------------------------------------------------------------------
// bftm_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module bftm_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  bftm_pkg::bftm_cmd_t  push_data,
    output logic                 full,
    input  logic                 pop,
    output bftm_pkg::bftm_cmd_t  pop_data,
    output logic                 empty
);
    import bftm_pkg::*;

    localparam int PW = $clog2(Q_DEPTH);
    localparam int CW = $clog2(Q_DEPTH + 1);

    bftm_cmd_t       entry_reg [Q_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            do_push;
    logic            do_pop;

    assign full     = (count_reg == CW'(Q_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ----- rtl/bftm_back.sv -----
// ----------------------------------------------------------------------------
// bftm_back
// Running width, scale multiply, iterative 32/16 divide and result register.
// ----------------------------------------------------------------------------
module bftm_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bftm_pkg::bftm_cfg_t  cfg,
    input  bftm_pkg::bftm_cmd_t  q_data,
    input  logic                 q_empty,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [15:0]          location,
    output logic                 overflowed,
    output logic                 last_of_run
);
    import bftm_pkg::*;

    localparam int          CNT_W    = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

    back_state_t state_reg;
    back_state_t state_next;

    bftm_cmd_t   cmd_reg;
    logic [15:0] run_reg;
    logic [31:0] prod_reg;
    logic [15:0] rem_reg;
    logic [15:0] quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [15:0] res_loc_reg;
    logic        res_ovf_reg;

    logic        out_valid_reg;
    logic [15:0] out_loc_reg;
    logic        out_ovf_reg;
    logic        out_last_reg;

    logic out_free;
    logic lead_emit;
    logic fin_emit;
    logic add_en;
    logic mul_en;
    logic chk_en;
    logic div_en;

    logic [15:0] run_sum;
    logic        sat;
    logic [16:0] trial;
    logic        q_bit;
    logic [15:0] rem_step;
    logic [15:0] quo_step;

    assign out_free = !out_valid_reg || out_ready;

    assign run_sum = run_reg + {{8{cmd_reg.glyph_width[7]}}, cmd_reg.glyph_width}
                   + cfg.extra_width;
    assign sat     = (cfg.scale_denom == '0) || (prod_reg[31:16] >= cfg.scale_denom);

    assign trial    = {rem_reg, quo_reg[15]};
    assign q_bit    = (trial >= {1'b0, cfg.scale_denom});
    assign rem_step = q_bit ? 16'(trial - {1'b0, cfg.scale_denom}) : trial[15:0];
    assign quo_step = {quo_reg[14:0], q_bit};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = q_data.first ? BK_LEAD : BK_ADD;
                end
            end
            BK_LEAD:
            begin
                if (out_free)
                begin
                    state_next = BK_ADD;
                end
            end
            BK_ADD:
            begin
                state_next = cmd_reg.is_return ? BK_EMIT : BK_MUL;
            end
            BK_MUL:
            begin
                state_next = BK_CHK;
            end
            BK_CHK:
            begin
                state_next = sat ? BK_EMIT : BK_DIV;
            end
            BK_DIV:
            begin
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = BK_EMIT;
                end
            end
            BK_EMIT:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop     = 1'b0;
        lead_emit = 1'b0;
        fin_emit  = 1'b0;
        add_en    = 1'b0;
        mul_en    = 1'b0;
        chk_en    = 1'b0;
        div_en    = 1'b0;
        unique case (state_reg)
            BK_IDLE: q_pop     = !q_empty;
            BK_LEAD: lead_emit = out_free;
            BK_ADD:  add_en    = 1'b1;
            BK_MUL:  mul_en    = 1'b1;
            BK_CHK:  chk_en    = 1'b1;
            BK_DIV:  div_en    = 1'b1;
            BK_EMIT: fin_emit  = out_free;
            default: q_pop     = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            run_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (lead_emit)
            begin
                run_reg <= '0;
            end
            else if (add_en)
            begin
                run_reg <= cmd_reg.is_return ? '0 : run_sum;
            end
            else if (fin_emit && cmd_reg.last)
            begin
                run_reg <= '0;
            end
            if (lead_emit || fin_emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg <= q_data;
        end
        if (add_en)
        begin
            res_loc_reg <= '0;
            res_ovf_reg <= 1'b0;
        end
        if (mul_en)
        begin
            prod_reg <= {16'd0, run_reg} * {16'd0, cfg.scale_numer};
        end
        if (chk_en)
        begin
            rem_reg <= prod_reg[31:16];
            quo_reg <= prod_reg[15:0];
            cnt_reg <= '0;
            if (sat)
            begin
                res_loc_reg <= 16'hFFFF;
                res_ovf_reg <= 1'b1;
            end
        end
        if (div_en)
        begin
            rem_reg     <= rem_step;
            quo_reg     <= quo_step;
            cnt_reg     <= cnt_reg + 1'b1;
            res_loc_reg <= quo_step;
            res_ovf_reg <= 1'b0;
        end
        if (lead_emit)
        begin
            out_loc_reg  <= '0;
            out_ovf_reg  <= 1'b0;
            out_last_reg <= 1'b0;
        end
        else if (fin_emit)
        begin
            out_loc_reg  <= res_loc_reg;
            out_ovf_reg  <= res_ovf_reg;
            out_last_reg <= cmd_reg.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign location    = out_loc_reg;
    assign overflowed  = out_ovf_reg;
    assign last_of_run = out_last_reg;

endmodule

// ----- rtl/bitmap_font_text_measure.sv -----
// ----------------------------------------------------------------------------
// bitmap_font_text_measure
// Measures text in a bitmap font, one character per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_*    : register writes (index, data), always ready; write only when idle.
//   s_axis_* : load transactions fill the glyph width table, measure
//              transactions add one character to the running width.
//   m_axis_* : scaled running width per measured character, plus a leading
//              zero for a character marked first of text.
// Loads produce no result and are taken one per cycle while s_axis_tready is
// high. A measure passes the registered table read and the back end: add,
// 16x16 multiply, overflow check, 16 restoring divide steps and the result
// register (a resetting return skips multiply and divide). The 16-step
// divider sets the rate; a first-of-text character adds a leading result.
// A two-entry queue lets the front keep accepting while the back end works.
// Reset clears the running width, the queue and restores register defaults;
// the glyph table is not cleared. A stalled m_axis_tready holds the result
// and backs up through the queue to s_axis_tready.
// ----------------------------------------------------------------------------
module bitmap_font_text_measure #(
    parameter int GLYPH_SLOTS = bftm_pkg::GLYPH_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] char_code, [15:8] glyph_width
    input  logic [1:0]  s_axis_tuser,   // [0] operation, [1] first_of_text
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] location
    output logic        m_axis_tuser,   // [0] overflowed
    output logic        m_axis_tlast
);
    import bftm_pkg::*;

    bftm_cfg_t cfg_reg;
    bftm_cmd_t push_data;
    bftm_cmd_t pop_data;
    logic      q_push;
    logic      q_full;
    logic      q_pop;
    logic      q_empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_char    <= 8'd0;
            cfg_reg.last_char     <= 8'd255;
            cfg_reg.extra_width   <= 16'd0;
            cfg_reg.scale_numer   <= 16'd1;
            cfg_reg.scale_denom   <= 16'd1;
            cfg_reg.return_resets <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_FIRST_CHAR:    cfg_reg.first_char    <= cfg_data[7:0];
                CFG_LAST_CHAR:     cfg_reg.last_char     <= cfg_data[7:0];
                CFG_EXTRA_WIDTH:   cfg_reg.extra_width   <= cfg_data;
                CFG_SCALE_NUMER:   cfg_reg.scale_numer   <= cfg_data;
                CFG_SCALE_DENOM:   cfg_reg.scale_denom   <= cfg_data;
                CFG_RETURN_RESETS: cfg_reg.return_resets <= cfg_data[0];
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    bftm_front #(
        .GLYPH_SLOTS (GLYPH_SLOTS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .operation     (s_axis_tuser[0]),
        .char_code     (s_axis_tdata[7:0]),
        .glyph_width   (s_axis_tdata[15:8]),
        .first_of_text (s_axis_tuser[1]),
        .last_of_text  (s_axis_tlast),
        .q_push        (q_push),
        .q_data        (push_data),
        .q_full        (q_full)
    );

    bftm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    bftm_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_data      (pop_data),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .location    (m_axis_tdata),
        .overflowed  (m_axis_tuser),
        .last_of_run (m_axis_tlast)
    );

endmodule
